/* rtl/pwst_pkg.sv */
// ----------------------------------------------------------------------------
// pwst_pkg
// Shared widths, register indexes and types for the polyline window select
// test block.
// ----------------------------------------------------------------------------
package pwst_pkg;

  // Coordinate width, signed Q16.16 at the default width
  localparam int CW = 32;
  // Width of a coordinate difference
  localparam int DW = CW + 1;
  // Width of a product of two differences
  localparam int PW = 2 * DW;
  // Width of a difference of two products
  localparam int XW = PW + 1;

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = ((2 * CW + 7) / 8) * 8;
  localparam int M_TDATA_W = 8;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_RECT_MIN_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RECT_MIN_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RECT_MAX_X    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RECT_MAX_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CROSSING_MODE = 3'd4;

  // Terms of one segment-against-side test, already sign-folded so that
  // t = tn / den and u = un / den
  typedef struct packed {
    logic signed [XW-1:0] den;
    logic signed [XW-1:0] tn;
    logic signed [XW-1:0] un;
  } side_terms_t;

endpackage

/* rtl/pwst_side_test.sv */
// ----------------------------------------------------------------------------
// pwst_side_test
// Exact crossing test of one segment against one rectangle side: both
// parameters must lie in [0, 1], checked as numerator against denominator.
// ----------------------------------------------------------------------------
module pwst_side_test (
  input  pwst_pkg::side_terms_t terms,
  output logic                  hit
);
  import pwst_pkg::*;

  logic signed [XW-1:0] den;
  logic signed [XW-1:0] tn;
  logic signed [XW-1:0] un;
  logic                 den_neg;
  logic                 den_zero;
  logic                 t_ok;
  logic                 u_ok;

  assign den      = terms.den;
  assign tn       = terms.tn;
  assign un       = terms.un;
  assign den_neg  = den[XW-1];
  assign den_zero = (den == '0);

  // den > 0: 0 <= n <= den ; den < 0: den <= n <= 0
  assign t_ok = den_neg ? (!(tn > 0) && (tn >= den)) : (!tn[XW-1] && (tn <= den));
  assign u_ok = den_neg ? (!(un > 0) && (un >= den)) : (!un[XW-1] && (un <= den));

  // parallel (zero denominator) never crosses
  assign hit = !den_zero && t_ok && u_ok;

endmodule

/* rtl/polyline_window_select_test.sv */
// ----------------------------------------------------------------------------
// polyline_window_select_test
// Tests streamed polyline vertices against a configured rectangle and gives
// one selected flag per polyline.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one vertex per transaction (tdata: vertex_x, vertex_y),
//   tlast marks the final vertex of a polyline. m_axis gives one transaction
//   per polyline, on the final vertex only (tdata bit 0: selected).
//   cfg writes rect_min_x/y, rect_max_x/y and crossing_mode by index; it is
//   always ready; write it only while the block is idle (not enforced).
//   Crossing mode selects a polyline if any vertex is inside the closed
//   rectangle or any segment meets a side; window mode needs all inside.
// Throughput and pipeline:
//   One vertex per cycle sustained while m_axis takes results. A last vertex
//   passes the input register, difference stage, product stage (ten 33x33
//   multipliers) and product-difference stage; then the side compares feed
//   the accumulator and result register, which gives its result on m_axis.
// Reset:
//   rst clears all pipeline valids, the running polyline state and the
//   configuration (rectangle at the origin, window mode).
// Stall:
//   While a result waits on m_axis with tready low, the whole pipeline
//   holds and s_axis_tready is low; no transaction is lost.
// ----------------------------------------------------------------------------
module polyline_window_select_test (
  input  logic                              clk,
  input  logic                              rst,
  // vertex stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pwst_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // vertex_x, vertex_y
  input  logic                              s_axis_tlast,  // last_vertex
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pwst_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // selected, zero pad
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwst_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [pwst_pkg::CW-1:0]           cfg_data
);
  import pwst_pkg::*;

  // Stage 0: accepted vertex b with previous vertex a
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic                 have_prev;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
  } stage0_t;

  // Stage 1: segment vector, corner offsets, rectangle size
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic                 have_prev;
    logic                 in_box;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] qx0;
    logic signed [DW-1:0] qx1;
    logic signed [DW-1:0] qy0;
    logic signed [DW-1:0] qy1;
    logic signed [DW-1:0] w;
    logic signed [DW-1:0] h;
  } stage1_t;

  // Stage 2: products
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic                 have_prev;
    logic                 in_box;
    logic signed [PW-1:0] p_ryw;
    logic signed [PW-1:0] p_rxh;
    logic signed [PW-1:0] p_qy0w;
    logic signed [PW-1:0] p_qy1w;
    logic signed [PW-1:0] p_qx0h;
    logic signed [PW-1:0] p_qx1h;
    logic signed [PW-1:0] p_qx0ry;
    logic signed [PW-1:0] p_qx1ry;
    logic signed [PW-1:0] p_qy0rx;
    logic signed [PW-1:0] p_qy1rx;
  } stage2_t;

  // Stage 3: sign-folded terms for the four sides
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        have_prev;
    logic        in_box;
    side_terms_t bot;
    side_terms_t rgt;
    side_terms_t top;
    side_terms_t lft;
  } stage3_t;

  // configuration
  logic signed [CW-1:0] rect_min_x;
  logic signed [CW-1:0] rect_min_y;
  logic signed [CW-1:0] rect_max_x;
  logic signed [CW-1:0] rect_max_y;
  logic                 crossing_mode;

  // running polyline state
  logic signed [CW-1:0] prev_x;
  logic signed [CW-1:0] prev_y;
  logic                 have_prev;
  logic                 any_hit;
  logic                 all_inside;

  stage0_t s0, s0_next;
  stage1_t s1, s1_next;
  stage2_t s2, s2_next;
  stage3_t s3, s3_next;

  logic out_valid;
  logic out_selected;
  logic sel_next;
  logic any_hit_next;
  logic all_inside_next;

  logic adv;      // whole pipeline moves
  logic accept;   // vertex transaction
  logic hit_bot, hit_rgt, hit_top, hit_lft;
  logic item_hit;

  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;

  assign in_x = s_axis_tdata[CW-1:0];
  assign in_y = s_axis_tdata[2*CW-1:CW];

  // Output register parts the sides: pipeline runs unless a result is stuck
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(M_TDATA_W-1)'(0), out_selected};
  assign cfg_ready     = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration registers; unknown indexes are ignored
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_min_x    <= '0;
      rect_min_y    <= '0;
      rect_max_x    <= '0;
      rect_max_y    <= '0;
      crossing_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RECT_MIN_X:    rect_min_x    <= cfg_data;
        REG_RECT_MIN_Y:    rect_min_y    <= cfg_data;
        REG_RECT_MAX_X:    rect_max_x    <= cfg_data;
        REG_RECT_MAX_Y:    rect_max_y    <= cfg_data;
        REG_CROSSING_MODE: crossing_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Previous vertex tracking, updated at the vertex transaction
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (accept) begin
      have_prev <= !s_axis_tlast;
    end
  end

  // payload only, meaningless while have_prev is low
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x <= in_x;
      prev_y <= in_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  always_comb begin
    s0_next.valid     = accept;
    s0_next.last      = s_axis_tlast;
    s0_next.have_prev = have_prev;
    s0_next.ax        = prev_x;
    s0_next.ay        = prev_y;
    s0_next.bx        = in_x;
    s0_next.by        = in_y;
  end

  // --------------------------------------------------------------------------
  // Stage 1: differences and point-in-rectangle for b
  // --------------------------------------------------------------------------
  always_comb begin
    s1_next.valid     = s0.valid;
    s1_next.last      = s0.last;
    s1_next.have_prev = s0.have_prev;
    s1_next.in_box    = (s0.bx >= rect_min_x) && (s0.bx <= rect_max_x) &&
                        (s0.by >= rect_min_y) && (s0.by <= rect_max_y);
    s1_next.rx  = DW'(s0.bx) - DW'(s0.ax);
    s1_next.ry  = DW'(s0.by) - DW'(s0.ay);
    s1_next.qx0 = DW'(rect_min_x) - DW'(s0.ax);
    s1_next.qx1 = DW'(rect_max_x) - DW'(s0.ax);
    s1_next.qy0 = DW'(rect_min_y) - DW'(s0.ay);
    s1_next.qy1 = DW'(rect_max_y) - DW'(s0.ay);
    s1_next.w   = DW'(rect_max_x) - DW'(rect_min_x);
    s1_next.h   = DW'(rect_max_y) - DW'(rect_min_y);
  end

  // --------------------------------------------------------------------------
  // Stage 2: products. Sides are axis-aligned, so each side needs at most
  // one product for den, one for tn and two shared ones for un.
  // --------------------------------------------------------------------------
  always_comb begin
    s2_next.valid     = s1.valid;
    s2_next.last      = s1.last;
    s2_next.have_prev = s1.have_prev;
    s2_next.in_box    = s1.in_box;
    s2_next.p_ryw     = PW'(s1.ry)  * PW'(s1.w);
    s2_next.p_rxh     = PW'(s1.rx)  * PW'(s1.h);
    s2_next.p_qy0w    = PW'(s1.qy0) * PW'(s1.w);
    s2_next.p_qy1w    = PW'(s1.qy1) * PW'(s1.w);
    s2_next.p_qx0h    = PW'(s1.qx0) * PW'(s1.h);
    s2_next.p_qx1h    = PW'(s1.qx1) * PW'(s1.h);
    s2_next.p_qx0ry   = PW'(s1.qx0) * PW'(s1.ry);
    s2_next.p_qx1ry   = PW'(s1.qx1) * PW'(s1.ry);
    s2_next.p_qy0rx   = PW'(s1.qy0) * PW'(s1.rx);
    s2_next.p_qy1rx   = PW'(s1.qy1) * PW'(s1.rx);
  end

  // --------------------------------------------------------------------------
  // Stage 3: side terms. Bottom and left sides yield negated cross products, so
  // den, tn and un are negated together; that flips the sign of den and tn
  // products and swaps the un operands.
  // --------------------------------------------------------------------------
  always_comb begin
    s3_next.valid     = s2.valid;
    s3_next.last      = s2.last;
    s3_next.have_prev = s2.have_prev;
    s3_next.in_box    = s2.in_box;
    // bottom: (x0,y0) -> (x1,y0)
    s3_next.bot.den = XW'(s2.p_ryw);
    s3_next.bot.tn  = XW'(s2.p_qy0w);
    s3_next.bot.un  = XW'(s2.p_qy0rx) - XW'(s2.p_qx0ry);
    // right: (x1,y0) -> (x1,y1)
    s3_next.rgt.den = XW'(s2.p_rxh);
    s3_next.rgt.tn  = XW'(s2.p_qx1h);
    s3_next.rgt.un  = XW'(s2.p_qx1ry) - XW'(s2.p_qy0rx);
    // top: (x1,y1) -> (x0,y1)
    s3_next.top.den = XW'(s2.p_ryw);
    s3_next.top.tn  = XW'(s2.p_qy1w);
    s3_next.top.un  = XW'(s2.p_qx1ry) - XW'(s2.p_qy1rx);
    // left: (x0,y1) -> (x0,y0)
    s3_next.lft.den = XW'(s2.p_rxh);
    s3_next.lft.tn  = XW'(s2.p_qx0h);
    s3_next.lft.un  = XW'(s2.p_qy1rx) - XW'(s2.p_qx0ry);
  end

  // pipeline registers: valids reset, payload follows
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (adv) begin
      s0 <= s0_next;
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: side compares, accumulation and result register
  // --------------------------------------------------------------------------
  pwst_side_test u_side_bot (.terms(s3.bot), .hit(hit_bot));
  pwst_side_test u_side_rgt (.terms(s3.rgt), .hit(hit_rgt));
  pwst_side_test u_side_top (.terms(s3.top), .hit(hit_top));
  pwst_side_test u_side_lft (.terms(s3.lft), .hit(hit_lft));

  always_comb begin
    item_hit = s3.in_box ||
               (s3.have_prev && (hit_bot || hit_rgt || hit_top || hit_lft));
    any_hit_next    = any_hit || item_hit;
    all_inside_next = all_inside && s3.in_box;
    // mode is sampled on the last vertex
    sel_next        = crossing_mode ? any_hit_next : all_inside_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_hit    <= 1'b0;
      all_inside <= 1'b1;
      out_valid  <= 1'b0;
    end else if (adv) begin
      out_valid <= s3.valid && s3.last;
      if (s3.valid) begin
        if (s3.last) begin
          any_hit    <= 1'b0;
          all_inside <= 1'b1;
        end else begin
          any_hit    <= any_hit_next;
          all_inside <= all_inside_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_selected <= sel_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a last vertex ends the polyline: no previous vertex afterwards
  a_last_clears_prev: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> !have_prev)
    else $error("previous vertex survived a last vertex");

  // a non-last vertex becomes the start of the next segment
  a_prev_follows: assert property (@(posedge clk) disable iff (rst)
    accept && !s_axis_tlast |=> have_prev && (prev_x == $past(in_x)) &&
                                (prev_y == $past(in_y)))
    else $error("previous vertex not captured");

  // a result appears only for a last vertex leaving the pipeline
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(s3.valid && s3.last))
    else $error("result without a last vertex");

  // finishing a polyline restores the accumulator
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    adv && s3.valid && s3.last |=> !any_hit && all_inside)
    else $error("accumulator not cleared after a polyline");

  // a waiting result holds the pipeline and the accumulator
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> $stable(s3) && $stable(any_hit))
    else $error("pipeline moved while result stalled");

endmodule

/* tb/sv/polyline_window_select_test_tb.sv */
// ----------------------------------------------------------------------------
// polyline_window_select_test_tb
// Self-checking bench for the polyline window select test block. Vertices go
// in on s_axis in bursts with random gaps, one selected flag per polyline
// comes back on m_axis under a stalling sink. A scoreboard class tracks the
// rectangle, the selection mode and the running polyline state, predicts the
// flag of every finished polyline and checks each result transaction in order.
// ----------------------------------------------------------------------------
module polyline_window_select_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwst_pkg::*;

  // Cycles with no transaction at all before the run is declared hung
  localparam int     WATCHDOG_LIMIT = 2000;
  // Pipeline is five stages deep; give it some slack after the last result
  localparam int     DRAIN_CYCLES   = 12;
  // Long sink hold-off, long enough to back the pipeline up into s_axis
  localparam int     RX_HOLD_CYCLES = 96;
  // 1.0 in Q16.16
  localparam longint ONE            = 64'sd65536;
  localparam longint COORD_MIN      = -(64'sd1 <<< (CW - 1));
  localparam longint COORD_MAX      = (64'sd1 <<< (CW - 1)) - 64'sd1;

  // --------------------------------------------------------------------------
  // Scoreboard: rectangle and mode, running polyline state, pending flags
  // --------------------------------------------------------------------------
  class polyline_select_scoreboard;
    longint box_x0, box_y0, box_x1, box_y1;
    bit     crossing;
    longint last_x, last_y;
    bit     have_last, touched, all_in;
    bit     expected_selected[$];

    function new();
      box_x0   = 0;
      box_y0   = 0;
      box_x1   = 0;
      box_y1   = 0;
      crossing = 1'b0;
      clear_polyline();
    endfunction

    function void clear_polyline();
      last_x    = 0;
      last_y    = 0;
      have_last = 1'b0;
      touched   = 1'b0;
      all_in    = 1'b1;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] data);
      case (idx)
        REG_RECT_MIN_X:    box_x0 = longint'($signed(data));
        REG_RECT_MIN_Y:    box_y0 = longint'($signed(data));
        REG_RECT_MAX_X:    box_x1 = longint'($signed(data));
        REG_RECT_MAX_Y:    box_y1 = longint'($signed(data));
        REG_CROSSING_MODE: crossing = data[0];
        default: ;  // unmapped index, write dropped
      endcase
    endfunction

    // 2-D cross product a x b, exact
    function logic signed [127:0] cross2(longint ax, longint ay, longint bx, longint by);
      logic signed [127:0] wax, way, wbx, wby;
      wax = ax;
      way = ay;
      wbx = bx;
      wby = by;
      return wax * wby - way * wbx;
    endfunction

    // Segment a-b against c-d. Both parameters compared as numerator against
    // denominator, ends included; a zero denominator (parallel) never crosses.
    function bit segs_meet(longint ax, longint ay, longint bx, longint by,
                           longint cx, longint cy, longint dx, longint dy);
      longint rx, ry, sx, sy, qx, qy;
      logic signed [127:0] den, tn, un;
      rx  = bx - ax;
      ry  = by - ay;
      sx  = dx - cx;
      sy  = dy - cy;
      qx  = cx - ax;
      qy  = cy - ay;
      den = cross2(rx, ry, sx, sy);
      if (den == 0) return 1'b0;
      tn = cross2(qx, qy, sx, sy);
      un = cross2(qx, qy, rx, ry);
      if (den < 0) begin
        den = -den;
        tn  = -tn;
        un  = -un;
      end
      return tn >= 0 && tn <= den && un >= 0 && un <= den;
    endfunction

    // Four sides walked from the corners as configured, inverted or not
    function bit segment_hits_box(longint ax, longint ay, longint bx, longint by);
      return segs_meet(ax, ay, bx, by, box_x0, box_y0, box_x1, box_y0) ||
             segs_meet(ax, ay, bx, by, box_x1, box_y0, box_x1, box_y1) ||
             segs_meet(ax, ay, bx, by, box_x1, box_y1, box_x0, box_y1) ||
             segs_meet(ax, ay, bx, by, box_x0, box_y1, box_x0, box_y0);
    endfunction

    // One accepted vertex transaction
    function void note_vertex(logic [CW-1:0] xb, logic [CW-1:0] yb, bit last);
      longint x, y;
      bit     in_box;
      bit     want_sel;
      x      = longint'($signed(xb));
      y      = longint'($signed(yb));
      in_box = x >= box_x0 && x <= box_x1 && y >= box_y0 && y <= box_y1;
      if (in_box || (have_last && segment_hits_box(last_x, last_y, x, y))) touched = 1'b1;
      if (!in_box) all_in = 1'b0;
      if (last) begin
        // mode is taken at the closing vertex, both rules tracked until then
        want_sel          = crossing ? touched : all_in;
        expected_selected = {expected_selected, want_sel};
        clear_polyline();
      end else begin
        last_x    = x;
        last_y    = y;
        have_last = 1'b1;
      end
    endfunction

    // One accepted result transaction; returns 0 and a reason on a miss
    function bit check_result(bit got, output string why);
      bit want;
      why = "";
      if (expected_selected.size() == 0) begin
        why = $sformatf("result selected=%0d with no polyline pending", got);
        return 1'b0;
      end
      want = expected_selected.pop_front();
      if (got !== want) begin
        why = $sformatf("selected=%0d, expected %0d", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_selected.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // vertex_x, vertex_y
  logic                 s_axis_tlast;   // last_vertex
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // selected, zero pad
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]        cfg_data;

  polyline_select_scoreboard sb = new();

  int error_count    = 0;
  int stalled_cycles = 0;
  int burst_left     = 0;
  // bumped by the stimulus to ask the sink for one long hold-off
  int rx_holds_asked = 0;

  polyline_window_select_test i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(string why);
    error_count++;
    $display("[%0t] mismatch: %s", $time, why);
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One vertex transaction. The sender works in bursts; between bursts tvalid
  // may drop for a random gap, sometimes not at all.
  task automatic send_vertex(longint x, longint y, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y[CW-1:0], x[CW-1:0]};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_vertex(x[CW-1:0], y[CW-1:0], last);
  endtask

  // Vertex in whole units of the Q16.16 grid
  task automatic send_q(longint x, longint y, bit last);
    send_vertex(x * ONE, y * ONE, last);
  endtask

  // Register write transaction; cfg_valid stays up for the next one
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, data);
  endtask

  // Full reprogram, led by a write to an unmapped index that must be ignored.
  // Upper bits of the mode word are junk on purpose.
  task automatic set_box(longint x0, longint y0, longint x1, longint y1, bit mode);
    logic [CW-1:0]        junk;
    logic [REG_IDX_W-1:0] bad_idx;
    junk    = $urandom;
    bad_idx = REG_IDX_W'(REG_CROSSING_MODE + 1 + $urandom_range(0, 2));
    write_reg(bad_idx, junk);
    write_reg(REG_RECT_MIN_X, x0[CW-1:0]);
    write_reg(REG_RECT_MIN_Y, y0[CW-1:0]);
    write_reg(REG_RECT_MAX_X, x1[CW-1:0]);
    write_reg(REG_RECT_MAX_Y, y1[CW-1:0]);
    write_reg(REG_CROSSING_MODE, {junk[CW-1:1], mode});
    cfg_valid <= 1'b0;
  endtask

  // Block goes idle: every flag back, then a drain wait so that vertices of an
  // unfinished polyline are through the pipeline before the next reprogram.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random coordinates and phases
  // --------------------------------------------------------------------------
  function automatic longint clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic longint rand_between(longint a, longint b);
    longint unsigned r;
    r = {$urandom, $urandom};
    return a + longint'(r % longint'(b - a + 1));
  endfunction

  // Mostly around the rectangle, some exactly on or next to a side, some
  // anywhere in the full coordinate range
  function automatic longint pick_coord(longint lo, longint hi);
    longint a, b, m;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    m = (b - a) / 2 + ONE;
    case ($urandom_range(0, 9))
      0:       return longint'($signed($urandom));
      1:       return ($urandom_range(0, 1) == 1) ? lo : hi;
      2:       return clamp_coord((($urandom_range(0, 1) == 1) ? lo : hi) +
                                  (($urandom_range(0, 1) == 1) ? 64'sd1 : -64'sd1));
      default: return rand_between(clamp_coord(a - m), clamp_coord(b + m));
    endcase
  endfunction

  // New rectangle and mode, then polylines of random length. The phase may
  // stop in the middle of a polyline, which carries over into the next one.
  task automatic random_phase(int n_items);
    longint cx, cy, hx, hy, x0, y0, x1, y1, t;
    int     len;
    cx = longint'($signed($urandom)) >>> $urandom_range(0, 14);
    cy = longint'($signed($urandom)) >>> $urandom_range(0, 14);
    hx = $urandom_range(1, 1 << 22);
    hy = $urandom_range(1, 1 << 22);
    x0 = clamp_coord(cx - hx);
    x1 = clamp_coord(cx + hx);
    y0 = clamp_coord(cy - hy);
    y1 = clamp_coord(cy + hy);
    case ($urandom_range(0, 9))
      0: begin            // whole plane
        x0 = COORD_MIN; y0 = COORD_MIN; x1 = COORD_MAX; y1 = COORD_MAX;
      end
      1: begin t = x0; x0 = x1; x1 = t; end   // inverted in x
      2: begin t = y0; y0 = y1; y1 = t; end   // inverted in y
      3: x1 = x0;                             // zero width
      4: begin            // pushed into the top right corner
        x1 = COORD_MAX; y1 = COORD_MAX; x0 = COORD_MAX - hx; y0 = COORD_MAX - hy;
      end
      5: begin            // pushed into the bottom left corner
        x0 = COORD_MIN; y0 = COORD_MIN; x1 = COORD_MIN + hx; y1 = COORD_MIN + hy;
      end
      default: ;
    endcase
    set_box(x0, y0, x1, y1, $urandom_range(0, 1) == 1);
    while (n_items > 0) begin
      len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
      for (int i = 0; i < len && n_items > 0; i++) begin
        send_vertex(pick_coord(x0, x1), pick_coord(y0, y1), i == len - 1);
        n_items--;
      end
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset config: point rectangle at the origin, window rule
    send_q(0, 0, 1'b1);
    drain_results();

    // 20x20 box around the origin, crossing rule
    set_box(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 1'b1);
    send_q(0, 0, 1'b1);                              // lone vertex inside
    send_q(-20, 0, 1'b0);  send_q(20, 0, 1'b1);      // straight through
    send_q(-20, 20, 1'b0); send_q(20, 20, 1'b1);     // parallel, above
    send_q(-20, 0, 1'b0);  send_q(0, 20, 1'b1);      // grazes a corner
    send_q(30, 30, 1'b0);  send_q(30, 30, 1'b1);     // zero length, outside
    send_q(-20, -10, 1'b0); send_q(-12, -10, 1'b1);  // collinear with bottom side
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);         // full-range diagonal
    drain_results();

    // Same box, window rule
    set_box(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 1'b0);
    send_q(0, 0, 1'b0); send_q(5, 5, 1'b0); send_q(-10, 10, 1'b1);
    drain_results();

    // Inverted in x: nothing inside, but the sides still catch segments
    set_box(10 * ONE, -10 * ONE, -10 * ONE, 10 * ONE, 1'b1);
    send_q(0, 0, 1'b1);
    send_q(-20, 0, 1'b0); send_q(20, 0, 1'b1);
    send_q(0, 0, 1'b0);   send_q(3, 3, 1'b0);        // left open
    drain_results();

    // Reprogram mid-polyline, then close it
    set_box(-10 * ONE, -10 * ONE, 10 * ONE, 10 * ONE, 1'b1);
    send_q(1, 1, 1'b1);
    drain_results();

    // Whole plane, window rule
    set_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(0, 0, 1'b1);
    drain_results();

    // Random part; two phases start with a long sink hold-off
    for (int p = 0; p < 8; p++) begin
      if (p == 2 || p == 6) rx_holds_asked++;
      random_phase(50);
    end
    drain_results();

    if (error_count == 0) begin
      $display("** polyline_window_select_test: PASSED **");
    end else begin
      $display("** polyline_window_select_test: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: changes style at random intervals, and holds off for a
  // long stretch on request while the sender keeps going.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int style, style_left, holds_done;
    m_axis_tready <= 1'b0;
    style      = 0;
    style_left = 0;
    holds_done = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_done != rx_holds_asked) begin
        holds_done = rx_holds_asked;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(10, 60);
      end
      style_left--;
      case (style)
        0:       m_axis_tready <= 1'b1;                        // no stalls
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0); // light stalls
        2:       m_axis_tready <= style_left[0];               // alternating
        default: m_axis_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
      endcase
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Result check on every m_axis transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    string why;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (!sb.check_result(m_axis_tdata[0], why)) report(why);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction means the block is hung or a
  // result never came
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d flags pending",
                 stalled_cycles, sb.pending());
        $display("** polyline_window_select_test: FAILED **");
        $finish;
      end
    end
  end

endmodule
